### hdl/sss_pkg.sv
`timescale 1ns / 1ps

package sss_pkg;

	localparam int MAX_PATTERN_DEF   = 16;
	localparam int POSITION_BITS_DEF = 16;
	localparam int BYTE_W            = 8;
	localparam int MATCH_POS_W       = 16;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TEXT = 1'b1;

	// One request as it leaves the input register, qualified by fire.
	typedef struct packed {
		logic              fire;
		logic              mode;
		logic [BYTE_W-1:0] data;
		logic              last;
	} step_t;

endpackage

### hdl/sss_pattern.sv
`timescale 1ns / 1ps

module sss_pattern #(
	parameter int MAX_PATTERN = sss_pkg::MAX_PATTERN_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  sss_pkg::step_t                               step,
	output logic [MAX_PATTERN-1:0][sss_pkg::BYTE_W-1:0]  pat_bytes,
	output logic [$clog2(MAX_PATTERN+1)-1:0]             pat_len,
	output logic                                         pat_ok
);
	import sss_pkg::*;

	localparam int LC_W  = $clog2(MAX_PATTERN + 2);
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	// Pattern bytes are kept newest first, so entry j lines up with window entry j.
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_q;
	logic [LC_W-1:0]                    load_cnt_q;
	logic [LEN_W-1:0]                   len_q;
	logic                               unusable_q;

	logic            load_fire;
	logic            room;
	logic [LC_W-1:0] cnt_inc;
	logic            unusable_next;

	assign load_fire = step.fire && (step.mode == MODE_LOAD);
	assign room      = load_cnt_q < LC_W'(MAX_PATTERN);
	assign cnt_inc   = (load_cnt_q <= LC_W'(MAX_PATTERN)) ? load_cnt_q + LC_W'(1) : load_cnt_q;

	always_comb begin
		unusable_next = (load_cnt_q == '0) ? 1'b0 : unusable_q;
		if ((step.data == '0) || !room) begin
			unusable_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			len_q      <= '0;
			unusable_q <= 1'b0;
		end else if (load_fire) begin
			unusable_q <= unusable_next;
			if (step.last) begin
				load_cnt_q <= '0;
				len_q      <= room ? LEN_W'(cnt_inc) : '0;
			end else begin
				load_cnt_q <= cnt_inc;
				if (load_cnt_q == '0) begin
					len_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_fire && room) begin
			pat_q[0] <= step.data;
			for (int j = 1; j < MAX_PATTERN; j++) begin
				pat_q[j] <= pat_q[j-1];
			end
		end
	end

	assign pat_bytes = pat_q;
	assign pat_len   = len_q;
	assign pat_ok    = !unusable_q;

endmodule

### hdl/sss_text.sv
`timescale 1ns / 1ps

module sss_text #(
	parameter int MAX_PATTERN   = sss_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = sss_pkg::POSITION_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  sss_pkg::step_t                               step,
	input  logic [MAX_PATTERN-1:0][sss_pkg::BYTE_W-1:0]  pat_bytes,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]             pat_len,
	input  logic                                         pat_ok,
	output logic                                         res_valid,
	output logic                                         res_found,
	output logic [sss_pkg::MATCH_POS_W-1:0]              res_pos
);
	import sss_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_q;
	logic [LEN_W-1:0]                   fill_q;
	logic [POSITION_BITS-1:0]           idx_q;
	logic                               finished_q;

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_next;
	logic [LEN_W-1:0]                   fill_next;
	logic [MAX_PATTERN-1:0]             lane_ok;
	logic                               hit;
	logic [POSITION_BITS-1:0]           len_m1;
	logic [POSITION_BITS-1:0]           start;

	logic clear;
	logic shift;
	logic set_finished;
	logic inc_idx;

	always_comb begin
		win_next[0] = step.data;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			win_next[j] = win_q[j-1];
		end
	end

	assign fill_next = (fill_q < LEN_W'(MAX_PATTERN)) ? fill_q + LEN_W'(1) : fill_q;

	// Lanes at or beyond the pattern length take no part in the compare.
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			lane_ok[j] = (LEN_W'(j) >= pat_len) || (pat_bytes[j] == win_next[j]);
		end
	end

	assign hit = pat_ok && (pat_len != '0) && (fill_next >= pat_len) && (&lane_ok);

	assign len_m1 = POSITION_BITS'(pat_len) - POSITION_BITS'(1);
	assign start  = (idx_q >= len_m1) ? idx_q - len_m1 : '0;

	always_comb begin
		res_valid    = 1'b0;
		res_found    = 1'b0;
		res_pos      = '0;
		clear        = 1'b0;
		shift        = 1'b0;
		set_finished = 1'b0;
		inc_idx      = 1'b0;
		if (step.fire) begin
			priority if (step.mode == MODE_LOAD) begin
				clear = 1'b1;
			end else if (step.data == '0) begin
				clear     = 1'b1;
				res_valid = !finished_q;
			end else if (finished_q) begin
				clear = step.last;
			end else begin
				shift = 1'b1;
				if (hit) begin
					res_valid = 1'b1;
					res_found = 1'b1;
					res_pos   = MATCH_POS_W'(start);
					if (step.last) begin
						clear = 1'b1;
					end else begin
						set_finished = 1'b1;
					end
				end else if (step.last) begin
					clear     = 1'b1;
					res_valid = 1'b1;
				end else begin
					inc_idx = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			idx_q      <= '0;
			finished_q <= 1'b0;
		end else if (clear) begin
			fill_q     <= '0;
			idx_q      <= '0;
			finished_q <= 1'b0;
		end else begin
			if (shift) begin
				fill_q <= fill_next;
			end
			if (set_finished) begin
				finished_q <= 1'b1;
			end
			if (inc_idx && (idx_q != '1)) begin
				idx_q <= idx_q + POSITION_BITS'(1);
			end
		end
	end

	// Window bytes past the fill count are never compared, so they need no reset.
	always_ff @(posedge clk) begin
		if (shift) begin
			win_q <= win_next;
		end
	end

endmodule

### hdl/substring_search_stream_top.sv
`timescale 1ns / 1ps
// A request passes the input register, then the result register drives out_valid;
// both hold while out_valid waits on out_ready. One request per cycle when not held;
// the window shift and parallel compare of all pattern lanes sit between the two.
// Reset (arst_n low, asynchronous): empty pattern, empty text window, no result pending.
// Pattern bytes are undefined until loaded.

module substring_search_stream_top #(
	parameter int MAX_PATTERN   = sss_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = sss_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [sss_pkg::BYTE_W-1:0]      data_byte,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [sss_pkg::MATCH_POS_W-1:0] match_position
);
	import sss_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic              valid_s1;
	logic              mode_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	logic                   out_valid_q;
	logic                   found_q;
	logic [MATCH_POS_W-1:0] pos_q;

	logic  advance;
	step_t step;

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_bytes;
	logic [LEN_W-1:0]                   pat_len;
	logic                               pat_ok;

	logic                   res_valid;
	logic                   res_found;
	logic [MATCH_POS_W-1:0] res_pos;

	// The held request moves on whenever the result register is free or being emptied.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	assign step.fire = valid_s1 && advance;
	assign step.mode = mode_s1;
	assign step.data = byte_s1;
	assign step.last = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	sss_pattern #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_pattern (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.pat_bytes(pat_bytes),
		.pat_len  (pat_len),
		.pat_ok   (pat_ok)
	);

	sss_text #(
		.MAX_PATTERN  (MAX_PATTERN),
		.POSITION_BITS(POSITION_BITS)
	) u_text (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.pat_bytes(pat_bytes),
		.pat_len  (pat_len),
		.pat_ok   (pat_ok),
		.res_valid(res_valid),
		.res_found(res_found),
		.res_pos  (res_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			found_q <= res_found;
			pos_q   <= res_pos;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign match_position = pos_q;

endmodule
